@@ hdl/b64enc_pkg.sv @@
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the alphabet lookup for the base64 encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

    // Opcodes of an input transfer
    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Register indexes (byte address 4*index)
    localparam logic REG_BREAK = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    localparam int          ADDR_W      = 3;
    localparam logic [7:0]  LIMIT_RESET = 8'd72;

    // Characters
    localparam logic [6:0] CH_CR  = 7'd13;
    localparam logic [6:0] CH_LF  = 7'd10;
    localparam logic [6:0] CH_PAD = 7'd61;
    localparam logic [6:0] CH_NUL = 7'd0;

    // Longest run of results caused by one input transfer
    localparam int RUN_MAX = 6;
    localparam int RUN_W   = $clog2(RUN_MAX + 1);

    typedef logic [6:0] t_char;

    // Configuration seen by the datapath
    typedef struct packed {
        logic       brk_en;
        logic [7:0] limit;
    } t_cfg;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic t_char sym(input logic [5:0] idx);
        t_char c;
        c = CH_NUL;
        if (idx < 6'd26) begin
            c = 7'd65 + {1'b0, idx};
        end else if (idx < 6'd52) begin
            c = 7'd71 + {1'b0, idx};        // 'a' - 26
        end else if (idx < 6'd62) begin
            c = {1'b0, idx} - 7'd4;         // '0' - 52
        end else if (idx == 6'd62) begin
            c = 7'd43;                      // '+'
        end else begin
            c = 7'd47;                      // '/'
        end
        return c;
    endfunction

endpackage

@@ hdl/b64enc_regs.sv @@
// ----------------------------------------------------------------------------
// b64enc_regs
// APB register file: line break enable and line length limit.
// ----------------------------------------------------------------------------
module b64enc_regs
    import b64enc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic       r_brk_en;
    logic [7:0] r_limit;
    logic       w_wr;
    logic       w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[2];

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brk_en <= 1'b0;
            r_limit  <= LIMIT_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_BREAK: r_brk_en <= pwdata[0];
                REG_LIMIT: r_limit  <= pwdata[7:0];
                default:   r_limit  <= r_limit;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        case (w_idx)
            REG_BREAK: prdata = {31'd0, r_brk_en};
            REG_LIMIT: prdata = {24'd0, r_limit};
            default:   prdata = 32'd0;
        endcase
    end

    assign o_cfg.brk_en = r_brk_en;
    assign o_cfg.limit  = r_limit;

endmodule

@@ hdl/base64_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder with optional CR LF line breaks.
// ----------------------------------------------------------------------------
// A push that leaves fewer than three bytes pending is taken and gives no
// result; it is accepted even while earlier characters still drain.
// A push that completes a group, or a finish, loads its whole run (4 or 6
// characters for a group, 4 for a padded tail, or a single end marker) into a
// shift register in the accept cycle; the run then leaves one character per
// output transfer, starting the cycle after the accept. The next item that
// produces output is accepted in the cycle the last character of the current
// run goes out, so the throughput is set by the one-character output.
// ----------------------------------------------------------------------------
module base64_stream_encoder
    import b64enc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_opcode,
    input  logic [7:0]        i_data_byte,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [6:0]        o_out_char,
    output logic              o_char_valid,
    output logic              o_last_in_run,
    output logic              o_message_end,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg w_cfg;

    b64enc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // encoder state
    logic [7:0]     r_pb0, r_pb1, n_pb0, n_pb1;
    logic [1:0]     r_pcnt, n_pcnt;
    logic [7:0]     r_col, n_col;
    // result shift register
    t_char          r_sh [RUN_MAX];
    t_char          n_sh [RUN_MAX];
    logic [RUN_W-1:0] r_cnt, n_cnt;
    logic           r_end, n_end;
    logic           r_marker, n_marker;

    logic           w_in_xfer, w_out_xfer, w_quiet, w_buf_free;
    logic [7:0]     w_col_inc;
    logic           w_brk;

    // handshakes
    assign w_quiet    = (i_opcode == OP_PUSH) && (r_pcnt < 2'd2);
    assign w_buf_free = (r_cnt == '0) || ((r_cnt == RUN_W'(1)) && i_out_ready);
    assign o_in_ready = w_quiet || w_buf_free;
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = o_out_valid && i_out_ready;

    // column count after a group, saturating
    assign w_col_inc = (r_col > 8'd251) ? 8'hFF : (r_col + 8'd4);
    assign w_brk     = w_cfg.brk_en && (w_col_inc >= w_cfg.limit);

    // next state and run load
    always_comb begin
        n_pb0    = r_pb0;
        n_pb1    = r_pb1;
        n_pcnt   = r_pcnt;
        n_col    = r_col;
        n_end    = r_end;
        n_marker = r_marker;
        n_cnt    = r_cnt;
        for (int i = 0; i < RUN_MAX; i++) begin
            n_sh[i] = r_sh[i];
        end
        // shift only when a character leaves
        if (w_out_xfer) begin
            n_cnt = r_cnt - RUN_W'(1);
            for (int i = 0; i < RUN_MAX - 1; i++) begin
                n_sh[i] = r_sh[i + 1];
            end
        end

        if (w_in_xfer) begin
            if (w_quiet) begin
                // hold the byte
                if (r_pcnt[0]) begin
                    n_pb1 = i_data_byte;
                end else begin
                    n_pb0 = i_data_byte;
                end
                n_pcnt = r_pcnt + 2'd1;
            end else if (i_opcode == OP_PUSH) begin
                // full group
                n_sh[0]  = sym(r_pb0[7:2]);
                n_sh[1]  = sym({r_pb0[1:0], r_pb1[7:4]});
                n_sh[2]  = sym({r_pb1[3:0], i_data_byte[7:6]});
                n_sh[3]  = sym(i_data_byte[5:0]);
                n_sh[4]  = CH_CR;
                n_sh[5]  = CH_LF;
                n_cnt    = w_brk ? RUN_W'(6) : RUN_W'(4);
                n_col    = w_brk ? 8'd0 : w_col_inc;
                n_pcnt   = 2'd0;
                n_end    = 1'b0;
                n_marker = 1'b0;
            end else begin
                // finish: padded tail or bare marker
                n_end    = 1'b1;
                n_pcnt   = 2'd0;
                n_col    = 8'd0;
                n_sh[0]  = sym(r_pb0[7:2]);
                n_sh[3]  = CH_PAD;
                if (r_pcnt == 2'd0) begin
                    n_sh[0]  = CH_NUL;
                    n_cnt    = RUN_W'(1);
                    n_marker = 1'b1;
                end else if (r_pcnt == 2'd1) begin
                    n_sh[1]  = sym({r_pb0[1:0], 4'd0});
                    n_sh[2]  = CH_PAD;
                    n_cnt    = RUN_W'(4);
                    n_marker = 1'b0;
                end else begin
                    n_sh[1]  = sym({r_pb0[1:0], r_pb1[7:4]});
                    n_sh[2]  = sym({r_pb1[3:0], 2'd0});
                    n_cnt    = RUN_W'(4);
                    n_marker = 1'b0;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt   <= 2'd0;
            r_col    <= 8'd0;
            r_cnt    <= '0;
            r_end    <= 1'b0;
            r_marker <= 1'b0;
        end else begin
            r_pcnt   <= n_pcnt;
            r_col    <= n_col;
            r_cnt    <= n_cnt;
            r_end    <= n_end;
            r_marker <= n_marker;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pb0 <= n_pb0;
        r_pb1 <= n_pb1;
        for (int i = 0; i < RUN_MAX; i++) begin
            r_sh[i] <= n_sh[i];
        end
    end

    // output fields
    assign o_out_valid   = (r_cnt != '0);
    assign o_out_char    = r_sh[0];
    assign o_char_valid  = !r_marker;
    assign o_last_in_run = (r_cnt == RUN_W'(1));
    assign o_message_end = r_end && (r_cnt == RUN_W'(1));

endmodule

@@ hdl/b64enc_checker.sv @@
// ----------------------------------------------------------------------------
// b64enc_checker
// Port-level checks of the encoder output stream, bound to the top level.
// ----------------------------------------------------------------------------
module b64enc_checker
    import b64enc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              i_opcode,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [6:0]        o_out_char,
    input logic              o_char_valid,
    input logic              o_last_in_run,
    input logic              o_message_end
);

    // end of message closes a run
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_message_end) |-> o_last_in_run)
        else $error("message end without last_in_run");

    // a bare marker is only the end of a message and carries no character
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_char_valid) |-> (o_message_end && o_out_char == CH_NUL))
        else $error("bad end marker");

    // a stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_char)))
        else $error("output changed while stalled");

    // a finish with output pending cannot be taken before the run ends
    a_finish_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_opcode == OP_FINISH && o_out_valid && !o_last_in_run)
            |-> !o_in_ready)
        else $error("finish accepted while a run drains");

endmodule

bind base64_stream_encoder b64enc_checker u_b64enc_checker (.*);
